/* design/utcdst_pkg.sv */
// ----------------------------------------------------------------------------
// utcdst_pkg
// Types, codes and calendar helpers shared by the UTC to local time resolver.
// ----------------------------------------------------------------------------
package utcdst_pkg;

    localparam int YEAR_MIN           = 1601;
    localparam int YEAR_MAX           = 30827;
    localparam int MAX_OFFSET_MINUTES = 1440;
    localparam int MIN_PER_DAY        = 24 * 60;
    localparam int QDEPTH             = 2;
    localparam int QPTR_W             = $clog2(QDEPTH);
    localparam int QCNT_W             = $clog2(QDEPTH + 1);
    localparam int CFG_INDEX_W        = 3;
    localparam int CFG_DATA_W         = 54;

    localparam logic [2:0] ST_UNKNOWN       = 3'd0;
    localparam logic [2:0] ST_STANDARD      = 3'd1;
    localparam logic [2:0] ST_DAYLIGHT      = 3'd2;
    localparam logic [2:0] ST_INVALID       = 3'd3;
    localparam logic [2:0] ST_NOT_SUPPORTED = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_BIAS     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STANDARD_BIAS = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DAYLIGHT_BIAS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STANDARD_RULE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DAYLIGHT_RULE = 3'd4;

    typedef struct packed {
        logic [14:0] utc_year;
        logic [3:0]  utc_month;
        logic [4:0]  utc_day;
        logic [4:0]  utc_hour;
        logic [5:0]  utc_minute;
        logic [5:0]  utc_second;
        logic [9:0]  utc_millis;
        logic [14:0] rule_year;
        logic        strict_mode;
    } req_t;

    typedef struct packed {
        logic [2:0]  zone_status;
        logic [14:0] local_year;
        logic [3:0]  local_month;
        logic [4:0]  local_day;
        logic [2:0]  local_weekday;
        logic [4:0]  local_hour;
        logic [5:0]  local_minute;
        logic [5:0]  local_second;
        logic [9:0]  local_millis;
    } rsp_t;

    typedef struct packed {
        logic signed [11:0] base_bias;
        logic signed [12:0] standard_extra_bias;
        logic signed [12:0] daylight_extra_bias;
        logic [53:0]        standard_rule;
        logic [53:0]        daylight_rule;
    } cfg_t;

    typedef struct packed {
        logic [14:0] year;
        logic [3:0]  month;
        logic [2:0]  dow;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [9:0]  millis;
    } rule_t;

    // One classified request on its way from the front end to the back end.
    typedef struct packed {
        logic        early_invalid;
        logic        rule_ignored;
        logic        strict;
        logic [14:0] rule_year;
        logic [14:0] utc_year;
        logic [3:0]  utc_month;
        logic [4:0]  utc_day;
        logic [4:0]  utc_hour;
        logic [5:0]  utc_minute;
        logic [5:0]  utc_second;
        logic [9:0]  utc_millis;
        logic [2:0]  utc_dow;
        logic        utc_leap;
        logic [4:0]  utc_mlen;
        logic [50:0] std_start;
        logic [50:0] day_start;
    } job_t;

    typedef struct packed {
        logic        ok;
        logic [14:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  dow;
        logic [4:0]  hour;
        logic [5:0]  minute;
    } cand_t;

    function automatic logic year_ok(input logic [14:0] y);
        return (y >= 15'(YEAR_MIN)) && (y <= 15'(YEAR_MAX));
    endfunction

    // Quotient by 100 through a scaled reciprocal; exact over 15-bit years.
    function automatic logic [8:0] div100(input logic [14:0] y);
        logic [27:0] p;
        p = 28'(y) * 28'd5243;
        return p[27:19];
    endfunction

    function automatic logic leap_year(input logic [14:0] y);
        logic [8:0]  q;
        logic [14:0] r;
        q = div100(y);
        r = y - 15'(q) * 15'd100;
        return ((y[1:0] == 2'd0) && (r != 15'd0)) || ((r == 15'd0) && (q[1:0] == 2'd0));
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
        logic [4:0] ml;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: ml = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     ml = 5'd30;
            4'd2:                                        ml = lp ? 5'd29 : 5'd28;
            default:                                     ml = 5'd0;
        endcase
        return ml;
    endfunction

    // Days from March 1 to the first of the month, in a year starting in March.
    function automatic logic [8:0] month_offset(input logic [3:0] m);
        logic [8:0] off;
        case (m)
            4'd3:    off = 9'd0;
            4'd4:    off = 9'd31;
            4'd5:    off = 9'd61;
            4'd6:    off = 9'd92;
            4'd7:    off = 9'd122;
            4'd8:    off = 9'd153;
            4'd9:    off = 9'd184;
            4'd10:   off = 9'd214;
            4'd11:   off = 9'd245;
            4'd12:   off = 9'd275;
            4'd1:    off = 9'd306;
            4'd2:    off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

    // Day count from March 1 of year zero.
    function automatic logic [23:0] day_number(input logic [14:0] y, input logic [3:0] m,
                                               input logic [4:0] d);
        logic [14:0] yy;
        logic [8:0]  q;
        yy = (m <= 4'd2) ? y - 15'd1 : y;
        q  = div100(yy);
        return 24'(yy) * 24'd365 + 24'(yy[14:2]) - 24'(q) + 24'(q[8:2])
               + 24'(month_offset(m)) + 24'(d) - 24'd1;
    endfunction

    // March 1 of year zero was a Wednesday; the remainder by 7 uses a reciprocal.
    function automatic logic [2:0] weekday(input logic [23:0] dn);
        logic [23:0] n;
        logic [48:0] p;
        logic [23:0] r;
        n = dn + 24'd3;
        p = 49'(n) * 49'd19173962;
        r = n - 24'(p[48:27]) * 24'd7;
        return r[2:0];
    endfunction

    function automatic rule_t unpack_rule(input logic [53:0] r);
        rule_t s;
        s.millis = r[9:0];
        s.second = r[15:10];
        s.minute = r[21:16];
        s.hour   = r[26:22];
        s.day    = r[31:27];
        s.dow    = r[34:32];
        s.month  = r[38:35];
        s.year   = r[53:39];
        return s;
    endfunction

    function automatic logic time_ok(input rule_t s);
        return (s.hour <= 5'd23) && (s.minute <= 6'd59) && (s.second <= 6'd59)
               && (s.millis <= 10'd999);
    endfunction

    function automatic logic rule_relative(input rule_t s);
        return (s.year == 15'd0) && (s.month >= 4'd1) && (s.month <= 4'd12)
               && (s.dow <= 3'd6) && (s.day >= 5'd1) && (s.day <= 5'd5) && time_ok(s);
    endfunction

    function automatic logic rule_absolute(input rule_t s);
        return year_ok(s.year) && (s.month >= 4'd1) && (s.month <= 4'd12)
               && (s.day >= 5'd1) && (s.day <= month_len(s.month, leap_year(s.year)))
               && time_ok(s);
    endfunction

    function automatic logic signed [13:0] bias_sum(input logic signed [11:0] b,
                                                    input logic signed [12:0] x);
        return $signed({{2{b[11]}}, b}) + $signed({x[12], x});
    endfunction

    function automatic logic bias_in_range(input logic signed [13:0] v);
        return (v <= $signed(14'(MAX_OFFSET_MINUTES)))
               && (v >= -$signed(14'(MAX_OFFSET_MINUTES)));
    endfunction

    function automatic logic biases_ok(input cfg_t c);
        return bias_in_range(bias_sum(c.base_bias, 13'sd0))
               && bias_in_range(bias_sum(c.base_bias, c.standard_extra_bias))
               && bias_in_range(bias_sum(c.base_bias, c.daylight_extra_bias));
    endfunction

    // Day of the nth weekday; a fifth occurrence past the month end falls back a week.
    function automatic logic [4:0] rel_day(input logic [2:0] first, input logic [2:0] dow,
                                           input logic [4:0] n, input logic [4:0] mlen);
        logic [5:0] base;
        logic [5:0] dd;
        base = 6'(dow) + 6'd1 + 6'(n - 5'd1) * 6'd7;
        dd   = (first <= dow) ? base - 6'(first) : base + 6'd7 - 6'(first);
        if (dd > 6'(mlen))
        begin
            dd = dd - 6'd7;
        end
        return dd[4:0];
    endfunction

    // Local candidate: UTC minus the bias. A valid bias moves the date by one day at most.
    function automatic cand_t shift_cand(input job_t j, input logic signed [13:0] bias);
        cand_t              c;
        logic [10:0]        hm;
        logic signed [14:0] tot;
        logic [10:0]        rem;
        logic [21:0]        p;
        logic [4:0]         hr;
        hm      = 11'(j.utc_hour) * 11'd60 + 11'(j.utc_minute);
        tot     = $signed({4'b0, hm}) - $signed({bias[13], bias});
        c.year  = j.utc_year;
        c.month = j.utc_month;
        c.day   = j.utc_day;
        c.dow   = j.utc_dow;
        if (tot < 15'sd0)
        begin
            rem   = 11'(tot + $signed(15'(MIN_PER_DAY)));
            c.dow = (j.utc_dow == 3'd0) ? 3'd6 : j.utc_dow - 3'd1;
            if (j.utc_day == 5'd1)
            begin
                if (j.utc_month == 4'd1)
                begin
                    c.month = 4'd12;
                    c.year  = j.utc_year - 15'd1;
                    c.day   = 5'd31;
                end
                else
                begin
                    c.month = j.utc_month - 4'd1;
                    c.day   = (j.utc_month == 4'd3) ? (j.utc_leap ? 5'd29 : 5'd28)
                                                    : month_len(j.utc_month - 4'd1, 1'b0);
                end
            end
            else
            begin
                c.day = j.utc_day - 5'd1;
            end
        end
        else if (tot >= 15'(MIN_PER_DAY))
        begin
            rem   = 11'(tot - 15'(MIN_PER_DAY));
            c.dow = (j.utc_dow == 3'd6) ? 3'd0 : j.utc_dow + 3'd1;
            if (j.utc_day == j.utc_mlen)
            begin
                c.day = 5'd1;
                if (j.utc_month == 4'd12)
                begin
                    c.month = 4'd1;
                    c.year  = j.utc_year + 15'd1;
                end
                else
                begin
                    c.month = j.utc_month + 4'd1;
                end
            end
            else
            begin
                c.day = j.utc_day + 5'd1;
            end
        end
        else
        begin
            rem = tot[10:0];
        end
        p        = 22'(rem) * 22'd1093;
        hr       = p[20:16];
        c.hour   = hr;
        c.minute = 6'(rem - 11'(hr) * 11'd60);
        c.ok     = year_ok(c.year);
        return c;
    endfunction

    function automatic logic [50:0] stamp_key(input cand_t c, input logic [5:0] s,
                                              input logic [9:0] ms);
        return {c.year, c.month, c.day, c.hour, c.minute, s, ms};
    endfunction

endpackage

/* design/utc_to_local_dst_resolver.sv */
// ----------------------------------------------------------------------------
// utc_to_local_dst_resolver
// UTC to local time conversion with standard and daylight transition rules.
// ----------------------------------------------------------------------------
// Path: a request accepted by the front check stage is registered there, then
// written into a queue entry, and then loaded into the output register.
// Throughput: one request per cycle while the output is not stalled.
// A two-entry queue lets the front keep accepting while the output waits.
// Reset clears all handshake state and every configuration register to zero.
module utc_to_local_dst_resolver (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  utcdst_pkg::req_t                    req_data,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output utcdst_pkg::rsp_t                    rsp_data,
    input  logic                                cfg_we,
    input  logic [utcdst_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [utcdst_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import utcdst_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic fq_valid;
    logic fq_ready;
    job_t fq_data;
    logic qb_valid;
    logic qb_ready;
    job_t qb_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_BASE_BIAS:     cfg_next.base_bias           = cfg_wdata[11:0];
                CFG_STANDARD_BIAS: cfg_next.standard_extra_bias = cfg_wdata[12:0];
                CFG_DAYLIGHT_BIAS: cfg_next.daylight_extra_bias = cfg_wdata[12:0];
                CFG_STANDARD_RULE: cfg_next.standard_rule       = cfg_wdata[53:0];
                CFG_DAYLIGHT_RULE: cfg_next.daylight_rule       = cfg_wdata[53:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    utcdst_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .cfg       (cfg_reg),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_data)
    );

    utcdst_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    utcdst_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_data),
        .cfg       (cfg_reg),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

endmodule

/* design/utcdst_front.sv */
// ----------------------------------------------------------------------------
// utcdst_front
// Accepts requests, checks them against the configuration and resolves the
// two transition dates, placing relative rules in the rule year.
// ----------------------------------------------------------------------------
module utcdst_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  utcdst_pkg::req_t  req_data,
    input  utcdst_pkg::cfg_t  cfg,
    output logic              job_valid,
    input  logic              job_ready,
    output utcdst_pkg::job_t  job
);
    import utcdst_pkg::*;

    typedef struct packed {
        req_t        req;
        logic [14:0] ry;
        logic        ry_leap;
        logic        utc_leap;
        logic [4:0]  utc_mlen;
        logic        early_invalid;
        logic        rule_ignored;
        logic        s_rel;
        logic        d_rel;
        logic [23:0] dn_utc;
        logic [23:0] dn_s;
        logic [23:0] dn_d;
    } stage_a_t;

    stage_a_t   a_reg;
    stage_a_t   a_next;
    logic       a_valid_reg;
    logic       a_valid_next;
    rule_t      srule;
    rule_t      drule;
    logic       s_abs;
    logic       d_abs;
    logic       utc_ok;
    logic [2:0] s_first;
    logic [2:0] d_first;
    logic [4:0] s_day;
    logic [4:0] d_day;

    assign srule = unpack_rule(cfg.standard_rule);
    assign drule = unpack_rule(cfg.daylight_rule);

    always_comb
    begin
        a_next.req      = req_data;
        a_next.ry       = (req_data.rule_year == 15'd0) ? req_data.utc_year : req_data.rule_year;
        a_next.ry_leap  = leap_year(a_next.ry);
        a_next.utc_leap = leap_year(req_data.utc_year);
        a_next.utc_mlen = month_len(req_data.utc_month, a_next.utc_leap);
        a_next.s_rel    = rule_relative(srule);
        a_next.d_rel    = rule_relative(drule);
        s_abs           = rule_absolute(srule);
        d_abs           = rule_absolute(drule);
        utc_ok = year_ok(req_data.utc_year) && (req_data.utc_month >= 4'd1)
                 && (req_data.utc_month <= 4'd12) && (req_data.utc_day >= 5'd1)
                 && (req_data.utc_day <= a_next.utc_mlen) && (req_data.utc_hour <= 5'd23)
                 && (req_data.utc_minute <= 6'd59) && (req_data.utc_second <= 6'd59)
                 && (req_data.utc_millis <= 10'd999);
        a_next.early_invalid = !year_ok(a_next.ry) || !biases_ok(cfg)
                               || !(a_next.s_rel || s_abs || (srule.month == 4'd0))
                               || !(a_next.d_rel || d_abs || (drule.month == 4'd0))
                               || !utc_ok;
        // Among acceptable rules, only a month of zero is neither relative nor absolute.
        a_next.rule_ignored = (!a_next.s_rel && !s_abs) || (!a_next.d_rel && !d_abs);
        a_next.dn_utc = day_number(req_data.utc_year, req_data.utc_month, req_data.utc_day);
        a_next.dn_s   = day_number(a_next.ry, srule.month, 5'd1);
        a_next.dn_d   = day_number(a_next.ry, drule.month, 5'd1);
    end

    assign req_ready    = !a_valid_reg || job_ready;
    assign a_valid_next = req_ready ? req_valid : a_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            a_reg <= a_next;
        end
    end

    always_comb
    begin
        s_first = weekday(a_reg.dn_s);
        d_first = weekday(a_reg.dn_d);
        s_day   = rel_day(s_first, srule.dow, srule.day, month_len(srule.month, a_reg.ry_leap));
        d_day   = rel_day(d_first, drule.dow, drule.day, month_len(drule.month, a_reg.ry_leap));

        job.early_invalid = a_reg.early_invalid;
        job.rule_ignored  = a_reg.rule_ignored;
        job.strict        = a_reg.req.strict_mode;
        job.rule_year     = a_reg.ry;
        job.utc_year      = a_reg.req.utc_year;
        job.utc_month     = a_reg.req.utc_month;
        job.utc_day       = a_reg.req.utc_day;
        job.utc_hour      = a_reg.req.utc_hour;
        job.utc_minute    = a_reg.req.utc_minute;
        job.utc_second    = a_reg.req.utc_second;
        job.utc_millis    = a_reg.req.utc_millis;
        job.utc_dow       = weekday(a_reg.dn_utc);
        job.utc_leap      = a_reg.utc_leap;
        job.utc_mlen      = a_reg.utc_mlen;
        job.std_start = a_reg.s_rel
            ? {a_reg.ry, srule.month, s_day, srule.hour, srule.minute, srule.second, srule.millis}
            : {srule.year, srule.month, srule.day, srule.hour, srule.minute, srule.second,
               srule.millis};
        job.day_start = a_reg.d_rel
            ? {a_reg.ry, drule.month, d_day, drule.hour, drule.minute, drule.second, drule.millis}
            : {drule.year, drule.month, drule.day, drule.hour, drule.minute, drule.second,
               drule.millis};
    end

    assign job_valid = a_valid_reg;

endmodule

/* design/utcdst_queue.sv */
// ----------------------------------------------------------------------------
// utcdst_queue
// Short queue of classified requests between the front and back ends.
// ----------------------------------------------------------------------------
module utcdst_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  utcdst_pkg::job_t push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output utcdst_pkg::job_t pop_data
);
    import utcdst_pkg::*;

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue holds more entries than its depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not rise on a lone push");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count did not fall on a lone pop");

endmodule

/* design/utcdst_back.sv */
// ----------------------------------------------------------------------------
// utcdst_back
// Forms three local candidates, sets standard, daylight, unknown, invalid or
// not-supported status and holds the result in the output register.
// ----------------------------------------------------------------------------
module utcdst_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    output logic             job_ready,
    input  utcdst_pkg::job_t job,
    input  utcdst_pkg::cfg_t cfg,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output utcdst_pkg::rsp_t rsp_data
);
    import utcdst_pkg::*;

    rsp_t       rsp_reg;
    rsp_t       rsp_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       load;
    cand_t      cu;
    cand_t      cs;
    cand_t      cd;
    cand_t      ch;
    logic [2:0] st;
    logic       std_before_day;
    logic       day_before_std;

    assign job_ready = !rsp_valid_reg || rsp_ready;
    assign load      = job_valid && job_ready;

    always_comb
    begin
        cu = shift_cand(job, bias_sum(cfg.base_bias, 13'sd0));
        cs = shift_cand(job, bias_sum(cfg.base_bias, cfg.standard_extra_bias));
        cd = shift_cand(job, bias_sum(cfg.base_bias, cfg.daylight_extra_bias));
        std_before_day = stamp_key(cs, job.utc_second, job.utc_millis) < job.day_start;
        day_before_std = stamp_key(cd, job.utc_second, job.utc_millis) < job.std_start;

        if (job.rule_ignored)
        begin
            ch = cu;
            st = ST_UNKNOWN;
        end
        else if (job.std_start < job.day_start)
        begin
            ch = (!day_before_std && std_before_day) ? cs : cd;
            st = (!day_before_std && std_before_day) ? ST_STANDARD : ST_DAYLIGHT;
        end
        else if (job.std_start > job.day_start)
        begin
            ch = (!std_before_day && day_before_std) ? cd : cs;
            st = (!std_before_day && day_before_std) ? ST_DAYLIGHT : ST_STANDARD;
        end
        else
        begin
            // Both transitions at the same instant.
            ch = (cfg.daylight_extra_bias != 13'sd0) ? cd : cu;
            st = (cfg.daylight_extra_bias != 13'sd0) ? ST_DAYLIGHT : ST_UNKNOWN;
        end
        if (job.strict && (ch.year != job.rule_year))
        begin
            st = ST_NOT_SUPPORTED;
        end

        rsp_next = '0;
        if (job.early_invalid || !cu.ok || !cs.ok || !cd.ok)
        begin
            rsp_next.zone_status = ST_INVALID;
        end
        else if (job.strict && (cu.year != job.rule_year) && (cs.year != job.rule_year)
                 && (cd.year != job.rule_year))
        begin
            rsp_next.zone_status = ST_NOT_SUPPORTED;
        end
        else
        begin
            rsp_next.zone_status   = st;
            rsp_next.local_year    = ch.year;
            rsp_next.local_month   = ch.month;
            rsp_next.local_day     = ch.day;
            rsp_next.local_weekday = ch.dow;
            rsp_next.local_hour    = ch.hour;
            rsp_next.local_minute  = ch.minute;
            rsp_next.local_second  = job.utc_second;
            rsp_next.local_millis  = job.utc_millis;
        end
    end

    assign rsp_valid_next = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_reg.zone_status == ST_INVALID))
        |-> ((rsp_reg.local_year == 15'd0) && (rsp_reg.local_month == 4'd0)))
        else $error("invalid result carries a nonzero date");

    a_good_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && ((rsp_reg.zone_status == ST_UNKNOWN)
                           || (rsp_reg.zone_status == ST_STANDARD)
                           || (rsp_reg.zone_status == ST_DAYLIGHT)))
        |-> (year_ok(rsp_reg.local_year) && (rsp_reg.local_hour <= 5'd23)
             && (rsp_reg.local_minute <= 6'd59) && (rsp_reg.local_weekday <= 3'd6)))
        else $error("resolved local time out of range");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> rsp_valid_reg)
        else $error("loaded result not presented");

endmodule
